/* hw/rtl/rlebe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlebe_pkg
// Shared types and constants of the run-length byte encoder.
// ----------------------------------------------------------------------------
package rlebe_pkg;

    // results one source word may produce
    localparam int RESULT_SLOTS = 17;
    localparam int RCNT_W       = $clog2(RESULT_SLOTS + 1);

    // sequencer to packer
    typedef struct packed {
        logic       start;
        logic       push;
        logic       flush;
        logic       done;
        logic [7:0] data;
    } t_pack_cmd;

    // packer to sequencer
    typedef struct packed {
        logic       out_free;
        logic [3:0] fill;
    } t_pack_stat;

endpackage
`default_nettype wire

/* hw/rtl/rlebe_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlebe_packer
// Gathers packet bytes into output lanes and holds the result register.
// ----------------------------------------------------------------------------
module rlebe_packer #(
    parameter int OUT_LANES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rlebe_pkg::t_pack_cmd  i_cmd,
    output rlebe_pkg::t_pack_stat o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_word,
    output logic [3:0]            o_count,
    output logic                  o_done
);
    import rlebe_pkg::*;

    localparam int LW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    logic [7:0]        r_lane [OUT_LANES];
    logic [LW-1:0]     r_fill;
    logic [RCNT_W-1:0] r_rcnt;
    logic              r_out_valid;
    logic [63:0]       r_out_word;
    logic [3:0]        r_out_count;
    logic              r_out_done;

    logic        out_free;
    logic        full;
    logic        emit;
    logic        keep;
    logic [63:0] word;
    logic [3:0]  count;

    assign out_free = !r_out_valid || i_ready;
    assign full     = i_cmd.push && (r_fill == LW'(OUT_LANES - 1));
    assign emit     = full || i_cmd.flush;
    // results past the slot limit of a word are dropped
    assign keep     = emit && (r_rcnt < RCNT_W'(RESULT_SLOTS));
    assign count    = full ? 4'(OUT_LANES) : 4'(r_fill);

    always_comb begin
        word = '0;
        for (int i = 0; i < OUT_LANES; i++) begin
            word[8*i +: 8] = (i_cmd.push && r_fill == LW'(i)) ? i_cmd.data : r_lane[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rcnt      <= '0;
            r_fill      <= '0;
            for (int i = 0; i < OUT_LANES; i++) begin
                r_lane[i] <= '0;
            end
        end else begin
            if (keep) begin
                r_out_valid <= 1'b1;
                r_out_word  <= word;
                r_out_count <= count;
                r_out_done  <= i_cmd.done;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.start) begin
                r_rcnt <= '0;
            end else if (keep) begin
                r_rcnt <= r_rcnt + 1'b1;
            end

            // unused lanes must read as zero
            if (emit) begin
                r_fill <= '0;
                for (int i = 0; i < OUT_LANES; i++) begin
                    r_lane[i] <= '0;
                end
            end else if (i_cmd.push) begin
                r_lane[r_fill] <= i_cmd.data;
                r_fill         <= r_fill + 1'b1;
            end
        end
    end

    assign o_stat.out_free = out_free;
    assign o_stat.fill     = 4'(r_fill);
    assign o_valid         = r_out_valid;
    assign o_word          = r_out_word;
    assign o_count         = r_out_count;
    assign o_done          = r_out_done;

endmodule
`default_nettype wire

/* hw/rtl/rle_byte_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rle_byte_encoder
// Run-length encoder: one source byte per word in, packed packet bytes out.
// Each word is accepted and its packet plan checked; packet bytes then go out
// one at a time through one byte-wide packing path, followed by the
// end-of-block flush, with carried lanes sent out alone first when needed,
// and the output may stall. A new word is taken only when the last is done.
// Synchronous active-low reset empties the run, pending bytes and lanes.
// ----------------------------------------------------------------------------
module rle_byte_encoder #(
    parameter int MAX_RUN   = 128,
    parameter int OUT_LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_packed_bytes,
    output logic [3:0]  o_valid_count,
    output logic        o_block_done
);
    import rlebe_pkg::*;

    localparam int CW         = $clog2(MAX_RUN + 3);
    localparam int PW         = $clog2(MAX_RUN + 2);
    localparam int DEPTH      = 1 << PW;
    localparam int RLW        = $clog2(MAX_RUN + 1);
    localparam int SLOT_COUNT = 5;
    localparam int LENW       = $clog2(SLOT_COUNT * (MAX_RUN + 1) + 1);

    localparam logic [2:0] SLOT_REP_A = 3'd0;
    localparam logic [2:0] SLOT_LIT_A = 3'd1;
    localparam logic [2:0] SLOT_REP_B = 3'd2;
    localparam logic [2:0] SLOT_LIT_B = 3'd3;
    localparam logic [2:0] SLOT_LIT_C = 3'd4;

    localparam logic [7:0] TOK_REPEAT = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OVF,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state r_state;

    // run and pending state
    logic           r_in_run;
    logic [7:0]     r_rv;
    logic [RLW-1:0] r_rl;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  r_head;
    logic [7:0]     r_p1;
    logic [7:0]     r_p2;
    logic           r_last;

    // packet plan of the current word
    logic [SLOT_COUNT-1:0] r_en;
    logic [RLW-1:0]        r_rep_a_len;
    logic [7:0]            r_rep_a_val;
    logic [RLW-1:0]        r_lit_a_n;
    logic [RLW-1:0]        r_rep_b_len;
    logic [7:0]            r_rep_b_val;
    logic [RLW-1:0]        r_lit_b_n;
    logic [RLW-1:0]        r_lit_c_n;

    // emission
    logic [2:0]     r_slot;
    logic [RLW-1:0] r_pos;
    logic [PW-1:0]  r_rd;
    logic [7:0]     r_rdata;
    logic [7:0]     r_mem [DEPTH];

    logic           acc_in;
    logic           taken;
    logic           run;
    logic           triple;
    logic           wr_en;
    logic [PW-1:0]  tail;
    logic [CW-1:0]  consumed;
    logic           n_in_run;
    logic [7:0]     n_rv;
    logic [RLW-1:0] n_rl;
    logic [CW-1:0]  n_cnt;
    logic           n_rep_a_en;
    logic [RLW-1:0] n_rep_a_len;
    logic [RLW-1:0] n_lit_a_n;
    logic           n_rep_b_en;
    logic [RLW-1:0] n_rep_b_len;
    logic [RLW-1:0] n_lit_b_n;
    logic [RLW-1:0] n_lit_c_n;
    logic [PW-1:0]  n_rd;

    logic           cur_rep;
    logic [RLW-1:0] cur_n;
    logic [7:0]     cur_val;
    logic [7:0]     token;
    logic [7:0]     byte_out;
    logic           pkt_end;
    logic [3:0]     nxt;
    logic [3:0]     first;
    logic [LENW-1:0] len;
    logic           ovf;
    logic           fill_nz;
    logic           emit_go;

    t_pack_cmd  cmd;
    t_pack_stat stat;

    // first enabled slot at or after a given one, with a found flag on top
    function automatic logic [3:0] first_from(input logic [SLOT_COUNT-1:0] en,
                                              input logic [2:0] from);
        logic [3:0] res;
        res = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (en[i] && 3'(i) >= from) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign acc_in  = i_valid && o_ready;
    assign tail    = r_head + PW'(r_cnt);

    // plan of the packets that this byte causes, in output order
    always_comb begin
        taken       = 1'b0;
        run         = r_in_run;
        triple      = 1'b0;
        wr_en       = 1'b0;
        consumed    = '0;
        n_rv        = r_rv;
        n_rl        = r_rl;
        n_cnt       = r_cnt;
        n_rep_a_en  = 1'b0;
        n_rep_a_len = r_rl;
        n_lit_a_n   = '0;
        n_rep_b_en  = 1'b0;
        n_rep_b_len = r_rl;
        n_lit_b_n   = '0;
        n_lit_c_n   = '0;

        if (r_in_run) begin
            if (i_data_byte == r_rv && r_rl < RLW'(MAX_RUN)) begin
                n_rl  = r_rl + 1'b1;
                taken = 1'b1;
                if (n_rl == RLW'(MAX_RUN)) begin
                    n_rep_a_en  = 1'b1;
                    n_rep_a_len = n_rl;
                    run         = 1'b0;
                    n_rl        = '0;
                end
            end else begin
                n_rep_a_en  = 1'b1;
                n_rep_a_len = r_rl;
                run         = 1'b0;
                n_rl        = '0;
            end
        end

        if (!taken) begin
            wr_en  = 1'b1;
            n_cnt  = r_cnt + 1'b1;
            triple = (n_cnt >= CW'(3)) && (i_data_byte == r_p1) && (r_p1 == r_p2);
            if (triple) begin
                // bytes before the triple leave as a literal, the triple opens a run
                n_lit_a_n = RLW'(n_cnt - CW'(3));
                consumed  = n_cnt;
                n_cnt     = '0;
                run       = 1'b1;
                n_rv      = i_data_byte;
                n_rl      = RLW'(3);
                if (MAX_RUN <= 3) begin
                    n_rep_b_en  = 1'b1;
                    n_rep_b_len = n_rl;
                    run         = 1'b0;
                    n_rl        = '0;
                end
            end else if (n_cnt == CW'(MAX_RUN + 2)) begin
                n_lit_a_n = RLW'(MAX_RUN);
                consumed  = CW'(MAX_RUN);
                n_cnt     = CW'(2);
            end
        end

        if (i_end_of_block) begin
            if (run) begin
                n_rep_b_en  = 1'b1;
                n_rep_b_len = n_rl;
                run         = 1'b0;
                n_rl        = '0;
            end
            if (n_cnt > CW'(MAX_RUN)) begin
                n_lit_b_n = RLW'(MAX_RUN);
                n_lit_c_n = RLW'(n_cnt - CW'(MAX_RUN));
            end else begin
                n_lit_b_n = RLW'(n_cnt);
            end
            consumed = consumed + n_cnt;
            n_cnt    = '0;
        end

        n_in_run = run;
    end

    // current slot of the plan
    always_comb begin
        unique case (r_slot)
            SLOT_REP_A: begin
                cur_rep = 1'b1;
                cur_n   = r_rep_a_len;
                cur_val = r_rep_a_val;
            end
            SLOT_LIT_A: begin
                cur_rep = 1'b0;
                cur_n   = r_lit_a_n;
                cur_val = '0;
            end
            SLOT_REP_B: begin
                cur_rep = 1'b1;
                cur_n   = r_rep_b_len;
                cur_val = r_rep_b_val;
            end
            SLOT_LIT_B: begin
                cur_rep = 1'b0;
                cur_n   = r_lit_b_n;
                cur_val = '0;
            end
            SLOT_LIT_C: begin
                cur_rep = 1'b0;
                cur_n   = r_lit_c_n;
                cur_val = '0;
            end
            default: begin
                cur_rep = 1'b0;
                cur_n   = '0;
                cur_val = '0;
            end
        endcase
    end

    assign token    = (cur_rep ? TOK_REPEAT : 8'h00) | {1'b0, 7'(cur_n - 1'b1)};
    assign byte_out = (r_pos == '0) ? token : (cur_rep ? cur_val : r_rdata);
    assign pkt_end  = cur_rep ? (r_pos == RLW'(1)) : (r_pos == cur_n);
    assign nxt      = first_from(r_en, r_slot + 3'd1);
    assign first    = first_from(r_en, SLOT_REP_A);

    always_comb begin
        len = '0;
        if (r_en[SLOT_REP_A]) len = len + LENW'(2);
        if (r_en[SLOT_LIT_A]) len = len + LENW'(r_lit_a_n) + LENW'(1);
        if (r_en[SLOT_REP_B]) len = len + LENW'(2);
        if (r_en[SLOT_LIT_B]) len = len + LENW'(r_lit_b_n) + LENW'(1);
        if (r_en[SLOT_LIT_C]) len = len + LENW'(r_lit_c_n) + LENW'(1);
    end

    // at the end of a block, carried lanes go out alone when they would push the word past its slots
    assign fill_nz = (stat.fill != 4'd0);
    assign ovf     = r_last && fill_nz &&
                     ((16'(stat.fill) + 16'(len)) > 16'(RESULT_SLOTS * OUT_LANES));
    assign emit_go = (r_state == S_EMIT) && stat.out_free;

    always_comb begin
        if (acc_in) begin
            n_rd = r_head;
        end else if (emit_go && !cur_rep && r_pos != '0) begin
            n_rd = r_rd + 1'b1;
        end else begin
            n_rd = r_rd;
        end
    end

    always_comb begin
        cmd.start = acc_in;
        cmd.push  = emit_go;
        cmd.data  = byte_out;
        cmd.flush = stat.out_free &&
                    ((r_state == S_OVF) || (r_state == S_FLUSH && fill_nz));
        priority if (r_state == S_FLUSH) begin
            cmd.done = 1'b1;
        end else if (r_state == S_OVF) begin
            cmd.done = 1'b0;
        end else begin
            cmd.done = r_last && pkt_end && !nxt[3];
        end
    end

    // pending byte store, read one byte ahead of the literal walk
    always_ff @(posedge i_clk) begin
        if (acc_in && wr_en) begin
            r_mem[tail] <= i_data_byte;
        end
        r_rdata <= r_mem[n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_run <= 1'b0;
            r_rv     <= '0;
            r_rl     <= '0;
            r_cnt    <= '0;
            r_head   <= '0;
            r_last   <= 1'b0;
            r_en     <= '0;
            r_slot   <= '0;
            r_pos    <= '0;
            r_rd     <= '0;
        end else begin
            r_rd <= n_rd;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_in_run    <= n_in_run;
                        r_rv        <= n_rv;
                        r_rl        <= n_rl;
                        r_cnt       <= n_cnt;
                        r_head      <= r_head + PW'(consumed);
                        r_last      <= i_end_of_block;
                        r_rep_a_len <= n_rep_a_len;
                        r_rep_a_val <= r_rv;
                        r_lit_a_n   <= n_lit_a_n;
                        r_rep_b_len <= n_rep_b_len;
                        r_rep_b_val <= n_rv;
                        r_lit_b_n   <= n_lit_b_n;
                        r_lit_c_n   <= n_lit_c_n;
                        r_en        <= {n_lit_c_n != '0, n_lit_b_n != '0, n_rep_b_en,
                                        n_lit_a_n != '0, n_rep_a_en};
                        if (!taken) begin
                            r_p2 <= r_p1;
                            r_p1 <= i_data_byte;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_slot <= first[2:0];
                    r_pos  <= '0;
                    priority if (ovf) begin
                        r_state <= S_OVF;
                    end else if (first[3]) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= r_last ? S_FLUSH : S_IDLE;
                    end
                end
                S_OVF: begin
                    if (stat.out_free) begin
                        r_state <= first[3] ? S_EMIT : S_FLUSH;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (pkt_end) begin
                            r_pos <= '0;
                            if (nxt[3]) begin
                                r_slot <= nxt[2:0];
                            end else begin
                                r_state <= r_last ? S_FLUSH : S_IDLE;
                            end
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!fill_nz || stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rlebe_packer #(
        .OUT_LANES (OUT_LANES)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_packed_bytes),
        .o_count (o_valid_count),
        .o_done  (o_block_done)
    );

endmodule
`default_nettype wire
